// ===== src/modulated_delay_vibrato_core_assert.svh =====
// assertion macros for the vibrato delay core
// needs a clock and a synchronous active-high reset at the point of use
`ifndef MODULATED_DELAY_VIBRATO_CORE_ASSERT_SVH
`define MODULATED_DELAY_VIBRATO_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define MDV_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mdv assertion failed");

// consequent holds in the same cycle as the antecedent
`define MDV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdv assertion failed");

// consequent holds in the cycle after the antecedent
`define MDV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdv assertion failed");

`endif

// ===== src/mdv_pkg.sv =====
// shared types and constants of the vibrato delay core
// no dependencies
`default_nettype none

package mdv_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int PHASE_BITS    = 24;
   localparam int COS_ENTRIES   = 1024;
   localparam int COS_BITS      = $clog2(COS_ENTRIES);
   localparam int MAX_DELAY_DEF = 1024;

   localparam int STEP_W      = 23;
   localparam int DEPTH_W     = 18;
   localparam int FRAC_W      = 8;
   localparam int A_W         = DEPTH_W - FRAC_W;
   localparam int CSR_DATA_W  = 23;
   localparam int CSR_INDEX_W = 2;

   // q30 fixed point, one needs 31 bits
   localparam int Q_W  = 31;
   localparam int CA_W = Q_W + 3;
   localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;

   // quarter-wave cosine polynomial coefficients, q30
   localparam logic [31:0] K_A = 32'd1324675879;
   localparam logic [31:0] K_B = 32'd272375562;
   localparam logic [31:0] K_C = 32'd22401992;
   localparam logic [31:0] K_D = 32'd987048;

   // wet 0.9 and dry 0.1 in q15
   localparam int GAIN_W = 15;
   localparam logic [GAIN_W-1:0] WET_GAIN = 15'd29491;
   localparam logic [GAIN_W-1:0] DRY_GAIN = 15'd3277;

   // shared multiplier operand width
   localparam int MUL_W  = 33;
   localparam int PROD_W = 64;

   localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 23'd6991;
   localparam logic [DEPTH_W-1:0] DEPTH_RST      = 18'd123;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH      = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          block_end_out;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WRITE,
      ST_ZSQ,
      ST_Z2,
      ST_Z3,
      ST_Z4,
      ST_TA,
      ST_TB,
      ST_TC,
      ST_TD,
      ST_WEIGHT,
      ST_DISP_MUL,
      ST_DISP,
      ST_INDEX,
      ST_MOD,
      ST_READ_A,
      ST_READ_B,
      ST_WET_A,
      ST_WET_B,
      ST_WET_SUM,
      ST_GAIN_WET,
      ST_GAIN_DRY,
      ST_ROUND,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/modulated_delay_vibrato_core.sv =====
// vibrato core: modulated delay line with cosine lfo and linear interpolation
// uses mdv_pkg and the assertion macros in modulated_delay_vibrato_core_assert.svh
//
//   channel | ports                             | moves
//   --------+-----------------------------------+------------------------------
//   req     | req_valid, req_stall, req_data    | one input sample per beat
//   rsp     | rsp_valid, rsp_stall, rsp_data    | one output sample per beat
//   csr     | csr_we, csr_index, csr_wdata      | register write, no wait
//
// an enabled sample steps the shared 33x33 multiplier through 13 products plus
// two store reads before the next accept, as the input stalls outside idle;
// only a store built shorter than 1024 entries can see the offset reach the
// length, and then it is reduced mod the length first, by restoring steps.
// a disabled sample goes straight from idle to the output state.
// reset is synchronous; the store needs no clearing pass: a fill count marks
// entries written since reset or the last depth / step write as live.
// a waiting result in the output register does not block the next accept.
`default_nettype none
`include "modulated_delay_vibrato_core_assert.svh"

module modulated_delay_vibrato_core
   import mdv_pkg::*;
#(
   parameter int MAX_DELAY = MAX_DELAY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_payload_type        req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_payload_type        rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // store address, index with room for the length, and a compare width
   localparam int ADDR_W = $clog2(MAX_DELAY);
   localparam int IDX_W  = ADDR_W + 1;
   localparam int WIDE_W = ((A_W > IDX_W) ? A_W : IDX_W) + 1;
   localparam int CNT_W  = $clog2(A_W);

   // mix arithmetic widths
   localparam int WET_W       = SAMPLE_BITS + FRAC_W + 1;
   localparam int ACC_W       = WET_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = GAIN_W + FRAC_W;
   localparam int Y_W         = ACC_W - ROUND_SHIFT;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (ROUND_SHIFT - 1));
   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;

   // control state
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff;
   logic                     enable_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [DEPTH_W-1:0]       depth_ff;
   logic [ADDR_W-1:0]        wp_ff;
   logic [IDX_W-1:0]         fill_ff;
   logic [PHASE_BITS-1:0]    phase_ff;

   // payload / datapath registers
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          be_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff;
   rsp_payload_type               rsp_data_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic [Q_W-1:0]                z_ff, z2_ff, z3_ff, z4_ff;
   logic signed [CA_W-1:0]        cos_acc_ff;
   logic [Q_W-1:0]                w_ff;
   logic [A_W-1:0]                a_ff;
   logic [FRAC_W-1:0]             frac_ff;
   logic [WIDE_W-1:0]             rem_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [ADDR_W-1:0]             ai_ff, bi_ff;
   logic signed [SAMPLE_BITS-1:0] sa_ff, sb_ff;
   logic signed [WET_W-1:0]       wet_ff;
   logic signed [ACC_W-1:0]       acc_ff;

   // delay store, one write and one registered read per cycle
   logic signed [SAMPLE_BITS-1:0] store [MAX_DELAY];
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic                          rvld_ff;

   // combinational signals
   logic                     accept;
   logic                     out_free;
   logic                     mem_we;
   logic [ADDR_W-1:0]        rd_addr;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_full;
   logic [Q_W-1:0]           prod_q;
   logic [A_W:0]             len_cand;
   logic [WIDE_W-1:0]        len_w;
   logic [WIDE_W-1:0]        wp_inc;
   logic [ADDR_W-1:0]        wp_next;
   logic [COS_BITS-1:0]      cos_k;
   logic [1:0]               quad;
   logic [Q_W-1:0]           r_q, y_q;
   logic                     cos_neg;
   logic signed [CA_W-1:0]   q_sum;
   logic [Q_W-1:0]           q_clamp;
   logic [Q_W:0]             w_sum;
   logic [DEPTH_W-1:0]       disp;
   logic [WIDE_W-1:0]        a_wide;
   logic                     a_lt_len;
   logic [WIDE_W-1:0]        ai_sum, ai_red;
   logic [WIDE_W-1:0]        ai_wide, bi_inc, bi_red;
   logic                     taps_ok;
   logic [WIDE_W-1:0]        mod_t, mod_red;
   logic [FRAC_W:0]          frac_inv;
   logic [ACC_W-1:0]         dry_sh;
   logic signed [ACC_W-1:0]  round_sum;
   logic signed [Y_W-1:0]    y_full;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // store length: floor(depth) + 1, capped at the store size
   assign len_cand = {1'b0, depth_ff[DEPTH_W-1:FRAC_W]} + (A_W + 1)'(1);
   assign len_w    = (WIDE_W'(len_cand) > WIDE_W'(MAX_DELAY)) ?
                     WIDE_W'(MAX_DELAY) : WIDE_W'(len_cand);

   // write pointer advance, wraps at the length
   assign wp_inc  = WIDE_W'(wp_ff) + WIDE_W'(1);
   assign wp_next = (wp_inc == len_w) ? '0 : wp_inc[ADDR_W-1:0];

   // lfo phase quantized to the cosine grid; quadrant picks mirror and sign
   assign cos_k   = phase_ff[PHASE_BITS-1 -: COS_BITS];
   assign quad    = cos_k[COS_BITS-1 -: 2];
   assign r_q     = Q_W'(cos_k[COS_BITS-3:0]) << (32 - COS_BITS);
   assign y_q     = quad[0] ? (Q30_ONE - r_q) : r_q;
   assign cos_neg = quad[1] ^ quad[0];

   // q30 view of the last product
   assign prod_q = prod_ff[Q_W+29:30];

   // polynomial result, clamped to [0, one], then folded to (cos + 1) / 2
   assign q_sum   = cos_acc_ff + $signed(CA_W'(prod_q));
   assign q_clamp = q_sum[CA_W-1] ? '0 :
                    (q_sum > $signed(CA_W'(Q30_ONE))) ? Q30_ONE : q_sum[Q_W-1:0];
   assign w_sum   = cos_neg ? ({1'b0, Q30_ONE} - {1'b0, q_clamp}) :
                              ({1'b0, Q30_ONE} + {1'b0, q_clamp});

   // displacement in q8 samples
   assign disp = prod_ff[DEPTH_W+29:30];

   // tap a = (wp + floor(disp)) mod len, with a already below len
   assign a_wide   = WIDE_W'(a_ff);
   assign a_lt_len = (a_wide < len_w);
   assign ai_sum   = WIDE_W'(wp_ff) + a_wide;
   assign ai_red   = (ai_sum >= len_w) ? (ai_sum - len_w) : ai_sum;

   // tap b is the entry after tap a
   assign ai_wide = WIDE_W'(ai_ff);
   assign bi_inc  = ai_wide + WIDE_W'(1);
   assign bi_red  = (bi_inc == len_w) ? '0 : bi_inc;
   assign taps_ok = (ai_wide < len_w) && (bi_red < len_w);

   // one restoring step of floor(disp) mod len
   assign mod_t   = {rem_ff[WIDE_W-2:0], a_ff[cnt_ff]};
   assign mod_red = (mod_t >= len_w) ? (mod_t - len_w) : mod_t;

   assign frac_inv = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, frac_ff};

   // mix: wet * 0.9 + dry * 0.1, round half up, saturate
   assign dry_sh    = {prod_ff[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
   assign round_sum = acc_ff + $signed(dry_sh) + $signed(ROUND_HALF);
   assign y_full    = round_sum[ACC_W-1:ROUND_SHIFT];
   assign y_sat     = (y_full > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
                      (y_full < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] :
                      y_full[SAMPLE_BITS-1:0];

   // shared multiplier, product registered every cycle
   assign mul_full = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = enable_ff ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE:    state_in = ST_ZSQ;
         ST_ZSQ:      state_in = ST_Z2;
         ST_Z2:       state_in = ST_Z3;
         ST_Z3:       state_in = ST_Z4;
         ST_Z4:       state_in = ST_TA;
         ST_TA:       state_in = ST_TB;
         ST_TB:       state_in = ST_TC;
         ST_TC:       state_in = ST_TD;
         ST_TD:       state_in = ST_WEIGHT;
         ST_WEIGHT:   state_in = ST_DISP_MUL;
         ST_DISP_MUL: state_in = ST_DISP;
         ST_DISP:     state_in = ST_INDEX;
         ST_INDEX:    state_in = a_lt_len ? ST_READ_A : ST_MOD;
         ST_MOD: begin
            if (cnt_ff == '0) begin
               state_in = ST_INDEX;
            end
         end
         ST_READ_A:   state_in = ST_READ_B;
         ST_READ_B:   state_in = ST_WET_A;
         ST_WET_A:    state_in = ST_WET_B;
         ST_WET_B:    state_in = ST_WET_SUM;
         ST_WET_SUM:  state_in = ST_GAIN_WET;
         ST_GAIN_WET: state_in = ST_GAIN_DRY;
         ST_GAIN_DRY: state_in = ST_ROUND;
         ST_ROUND:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // per-state controls: store access and multiplier operands
   always_comb begin
      mem_we  = (state_ff == ST_WRITE);
      rd_addr = (state_ff == ST_READ_A) ? ai_ff : bi_ff;
      mul_a   = '0;
      mul_b   = '0;
      unique case (state_ff)
         ST_ZSQ: begin
            mul_a = {2'b00, y_q};
            mul_b = {2'b00, y_q};
         end
         ST_Z2: begin
            mul_a = {2'b00, prod_q};
            mul_b = {2'b00, prod_q};
         end
         ST_Z3, ST_Z4: begin
            mul_a = {2'b00, prod_q};
            mul_b = {2'b00, z_ff};
         end
         ST_TA: begin
            mul_a = {1'b0, K_A};
            mul_b = {2'b00, z_ff};
         end
         ST_TB: begin
            mul_a = {1'b0, K_B};
            mul_b = {2'b00, z2_ff};
         end
         ST_TC: begin
            mul_a = {1'b0, K_C};
            mul_b = {2'b00, z3_ff};
         end
         ST_TD: begin
            mul_a = {1'b0, K_D};
            mul_b = {2'b00, z4_ff};
         end
         ST_DISP_MUL: begin
            mul_a = {{(MUL_W-DEPTH_W){1'b0}}, depth_ff};
            mul_b = {2'b00, w_ff};
         end
         ST_WET_A: begin
            mul_a = {{(MUL_W-SAMPLE_BITS){sa_ff[SAMPLE_BITS-1]}}, sa_ff};
            mul_b = {{(MUL_W-FRAC_W-1){1'b0}}, frac_inv};
         end
         ST_WET_B: begin
            mul_a = {{(MUL_W-SAMPLE_BITS){sb_ff[SAMPLE_BITS-1]}}, sb_ff};
            mul_b = {{(MUL_W-FRAC_W){1'b0}}, frac_ff};
         end
         ST_GAIN_WET: begin
            mul_a = {{(MUL_W-WET_W){wet_ff[WET_W-1]}}, wet_ff};
            mul_b = {{(MUL_W-GAIN_W){1'b0}}, WET_GAIN};
         end
         ST_GAIN_DRY: begin
            mul_a = {{(MUL_W-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
            mul_b = {{(MUL_W-GAIN_W){1'b0}}, DRY_GAIN};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // control registers, lfo and write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         step_ff      <= PHASE_STEP_RST;
         depth_ff     <= DEPTH_RST;
         wp_ff        <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
      end else begin
         state_ff <= state_in;

         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // sample goes in, pointer and lfo advance
         if (state_ff == ST_WRITE) begin
            wp_ff    <= wp_next;
            phase_ff <= phase_ff + PHASE_BITS'(step_ff);
            if (fill_ff != IDX_W'(MAX_DELAY)) begin
               fill_ff <= fill_ff + IDX_W'(1);
            end
         end

         // a depth or step write empties the line, phase is kept
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENABLE: enable_ff <= csr_wdata[0];
               CSR_PHASE_STEP: begin
                  step_ff <= csr_wdata[STEP_W-1:0];
                  wp_ff   <= '0;
                  fill_ff <= '0;
               end
               CSR_DEPTH: begin
                  depth_ff <= csr_wdata[DEPTH_W-1:0];
                  wp_ff    <= '0;
                  fill_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // delay store; entries past the fill count read as silence
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wp_ff] <= x_ff;
      end
      rdata_ff <= store[rd_addr];
      rvld_ff  <= (IDX_W'(rd_addr) < fill_ff);
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[PROD_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_ff   <= req_data.sample_in;
               be_ff  <= req_data.block_end;
               res_ff <= '0;
            end
         end
         ST_Z2:     z_ff  <= prod_q;
         ST_Z3:     z2_ff <= prod_q;
         ST_Z4:     z3_ff <= prod_q;
         ST_TA:     z4_ff <= prod_q;
         ST_TB:     cos_acc_ff <= $signed(CA_W'(Q30_ONE)) - $signed(CA_W'(prod_q));
         ST_TC:     cos_acc_ff <= cos_acc_ff + $signed(CA_W'(prod_q));
         ST_TD:     cos_acc_ff <= cos_acc_ff - $signed(CA_W'(prod_q));
         ST_WEIGHT: w_ff <= w_sum[Q_W:1];
         ST_DISP: begin
            a_ff    <= disp[DEPTH_W-1:FRAC_W];
            frac_ff <= disp[FRAC_W-1:0];
         end
         ST_INDEX: begin
            ai_ff  <= ai_red[ADDR_W-1:0];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(A_W - 1);
         end
         ST_MOD: begin
            rem_ff <= mod_red;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               a_ff <= mod_red[A_W-1:0];
            end
         end
         ST_READ_A:  bi_ff <= bi_red[ADDR_W-1:0];
         ST_READ_B:  sa_ff <= rvld_ff ? rdata_ff : '0;
         ST_WET_A:   sb_ff <= rvld_ff ? rdata_ff : '0;
         ST_WET_B:   wet_ff <= prod_ff[WET_W-1:0];
         ST_WET_SUM: wet_ff <= wet_ff + prod_ff[WET_W-1:0];
         ST_GAIN_DRY: acc_ff <= prod_ff[ACC_W-1:0];
         ST_ROUND:   res_ff <= y_sat;
         ST_DONE: begin
            if (out_free) begin
               rsp_data_ff.sample_out    <= res_ff;
               rsp_data_ff.block_end_out <= be_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // write pointer always inside the current line
   `MDV_ASSERT_HOLD(a_wp_in_line, clock, reset, (WIDE_W'(wp_ff) < len_w))
   // both taps inside the line when the reads go out
   `MDV_ASSERT_IMPLY(a_taps_in_line, clock, reset, (state_ff == ST_READ_A), taps_ok)
   // partial remainder stays below the length
   `MDV_ASSERT_IMPLY(a_mod_rem_bound, clock, reset, (state_ff == ST_MOD), (rem_ff < len_w))
   // an accepted sample always starts work
   `MDV_ASSERT_NEXT(a_accept_starts, clock, reset, accept, (state_ff != ST_IDLE))

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for modulated_delay_vibrato_core: a directed table, then random phases of samples
// checked field by field against a bit-true vibrato predictor held in this file
// depends on mdv_pkg and the core itself
module tb_top;
   import mdv_pkg::*;

   // predictor constants, kept apart from the design's own copies
   localparam int              DELAY_LEN  = 1024;
   localparam int              LFO_BITS   = 24;
   localparam longint unsigned COS_STEPS  = 1024;
   localparam longint          Q30        = 64'sd1073741824;
   localparam longint unsigned COEF_A     = 64'd1324675879;
   localparam longint unsigned COEF_B     = 64'd272375562;
   localparam longint unsigned COEF_C     = 64'd22401992;
   localparam longint unsigned COEF_D     = 64'd987048;
   localparam longint          WET_MIX    = 64'sd29491;
   localparam longint          DRY_MIX    = 64'sd3277;
   localparam longint          ROUND_HALF = 64'sd4194304;
   localparam longint          SAT_MAX    = 64'sd32767;
   localparam longint          SAT_MIN    = -64'sd32768;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index, write ignored

   localparam int ITEM_TARGET   = 1550;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_type;
   typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [CSR_INDEX_W-1:0]        index;
      logic [CSR_DATA_W-1:0]         value;
      req_payload_type               beat;
      bit                            typed;
      logic signed [SAMPLE_BITS-1:0] want;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // typed-in expectation travelling with the current request beat
   logic                   fixed_valid;
   rsp_payload_type        fixed_out;

   // predictor state and register copies
   logic                          cfg_enable;
   logic [STEP_W-1:0]             cfg_step;
   logic [DEPTH_W-1:0]            cfg_depth;
   logic signed [SAMPLE_BITS-1:0] line_store [DELAY_LEN];
   int unsigned                   line_pos;
   logic [LFO_BITS-1:0]           lfo_phase;

   rsp_payload_type pending [$];   // expected output beats, oldest first
   plan_row_type    plan [$];
   int              beats_in;      // request beats accepted by the core
   int              beats_sent;
   int              mismatches;
   int              cycle_count;

   modulated_delay_vibrato_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // cos(y * pi/2) for y in q30 over [0, 1], q30 result clamped to [0, 1]
   function automatic longint quarter_wave_cos(longint unsigned y);
      longint unsigned z, z2, z3, z4;
      longint          pos, neg, r;
      z   = (y * y) >> 30;
      z2  = (z * z) >> 30;
      z3  = (z2 * z) >> 30;
      z4  = (z3 * z) >> 30;
      pos = Q30 + longint'((COEF_B * z2) >> 30) + longint'((COEF_D * z4) >> 30);
      neg = longint'((COEF_A * z) >> 30) + longint'((COEF_C * z3) >> 30);
      r   = pos - neg;
      if (r < 0) r = 0;
      if (r > Q30) r = Q30;
      return r;
   endfunction

   // lfo gain (cos * 0.5 + 0.5) in q30 at the phase snapped to the table grid
   function automatic longint unsigned lfo_gain_q30(logic [LFO_BITS-1:0] phase);
      longint unsigned step_idx, turn, r;
      quadrant_type    quad;
      longint          c;
      step_idx = (64'(phase) * COS_STEPS) >> LFO_BITS;
      turn     = (step_idx << 32) / COS_STEPS;
      quad     = quadrant_type'(turn[31:30]);
      r        = turn & (Q30 - 1);
      case (quad)
         QUAD_I:   c = quarter_wave_cos(r);
         QUAD_II:  c = -quarter_wave_cos(Q30 - r);
         QUAD_III: c = -quarter_wave_cos(r);
         default:  c = quarter_wave_cos(Q30 - r);
      endcase
      return 64'(Q30 + c) >> 1;
   endfunction

   task automatic clear_delay_line();
      foreach (line_store[i]) line_store[i] = '0;
      line_pos = 0;
   endtask

   // one sample through the vibrato: store write, lfo advance, interpolated read, mix
   function automatic rsp_payload_type vibrato_sample(req_payload_type beat);
      rsp_payload_type res;
      int unsigned     len, tap, ai, bi;
      longint unsigned disp;
      longint          x, frac, wet, acc, y;
      x                 = longint'(beat.sample_in);
      res.block_end_out = beat.block_end;
      res.sample_out    = '0;
      if (!cfg_enable) return res;   // bypass: zero out, state frozen

      len = (cfg_depth >> 8) + 1;
      if (len > DELAY_LEN) len = DELAY_LEN;
      line_pos             = line_pos % len;
      line_store[line_pos] = beat.sample_in;
      line_pos             = (line_pos + 1) % len;

      lfo_phase = lfo_phase + cfg_step;
      disp      = (64'(cfg_depth) * lfo_gain_q30(lfo_phase)) >> 30;
      tap       = 32'(disp >> 8);
      frac      = longint'(disp & 64'd255);
      ai        = (line_pos + tap) % len;
      bi        = (line_pos + tap + 1) % len;

      wet = longint'(line_store[ai]) * (256 - frac) + longint'(line_store[bi]) * frac;
      acc = wet * WET_MIX + x * DRY_MIX * 256;
      y   = (acc + ROUND_HALF) >>> 23;
      if (y > SAT_MAX) y = SAT_MAX;
      if (y < SAT_MIN) y = SAT_MIN;
      res.sample_out = y[SAMPLE_BITS-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- scoreboard
   // one block at the rising edge: output beats are checked before the request
   // beat of the same edge is predicted, so the order is fixed
   always @(posedge clock) begin : scoreboard
      rsp_payload_type exp_beat;
      if (reset) begin
         cfg_enable = 1'b0;
         cfg_step   = PHASE_STEP_RST;
         cfg_depth  = DEPTH_RST;
         lfo_phase  = '0;
         clear_delay_line();
         pending.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending.size() == 0) begin
               $error("output beat with no sample pending: sample_out %0d block_end_out %0b",
                      rsp_data.sample_out, rsp_data.block_end_out);
               mismatches++;
            end else begin
               exp_beat = pending.pop_front();
               if (rsp_data.sample_out !== exp_beat.sample_out) begin
                  $error("sample_out expected %0d got %0d",
                         exp_beat.sample_out, rsp_data.sample_out);
                  mismatches++;
               end
               if (rsp_data.block_end_out !== exp_beat.block_end_out) begin
                  $error("block_end_out expected %0b got %0b",
                         exp_beat.block_end_out, rsp_data.block_end_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // the predictor runs on typed rows too, to keep its state in step
            exp_beat = vibrato_sample(req_data);
            pending.push_back(fixed_valid ? fixed_out : exp_beat);
            beats_in++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE: cfg_enable = csr_wdata[0];
               CSR_PHASE_STEP: begin
                  cfg_step = csr_wdata[STEP_W-1:0];
                  clear_delay_line();
               end
               CSR_DEPTH: begin
                  cfg_depth = csr_wdata[DEPTH_W-1:0];
                  clear_delay_line();
               end
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- driver tasks
   // all of these start and end at a falling edge

   task automatic drive_beat(input req_payload_type beat, input bit typed,
                             input logic signed [SAMPLE_BITS-1:0] want);
      rsp_payload_type fixed;
      fixed.sample_out    = want;
      fixed.block_end_out = beat.block_end;
      req_valid   <= 1'b1;
      req_data    <= beat;
      fixed_valid <= typed;
      fixed_out   <= fixed;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   // sender gap; the payload wanders while valid is low
   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      req_data  <= req_payload_type'(17'($urandom));
      repeat (cycles) @(negedge clock);
   endtask

   // register writes only once the core has drained every pending sample
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic plan_beat(input logic signed [SAMPLE_BITS-1:0] sample, input bit block_end,
                            input bit typed, input logic signed [SAMPLE_BITS-1:0] want);
      plan_row_type row;
      row.kind            = ROW_BEAT;
      row.index           = '0;
      row.value           = '0;
      row.beat.sample_in  = sample;
      row.beat.block_end  = block_end;
      row.typed           = typed;
      row.want            = want;
      plan.push_back(row);
   endtask

   task automatic plan_write(input logic [CSR_INDEX_W-1:0] index,
                             input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.value = value;
      row.beat  = '0;
      row.typed = 1'b0;
      row.want  = '0;
      plan.push_back(row);
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      req_payload_type        beat;
      logic [CSR_DATA_W-1:0]  word;
      logic [DEPTH_W-1:0]     depth_pick;
      logic [STEP_W-1:0]      step_pick;
      int                     phase_len, burst_left;
      bit                     gappy;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      fixed_valid = 1'b0;
      fixed_out   = '0;
      beats_in    = 0;
      beats_sent  = 0;
      mismatches  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out of reset the core is bypassed: zero out, block_end copied
      plan_beat(16'sh7fff, 1'b1, 1'b1, 16'sh0000);
      plan_beat(-16'sh8000, 1'b0, 1'b1, 16'sh0000);
      // reset step and depth, store length one
      plan_write(CSR_ENABLE, 23'd1);
      plan_beat(16'sh7fff, 1'b0, 1'b0, '0);
      plan_beat(-16'sh8000, 1'b1, 1'b0, '0);
      plan_beat(16'sh0000, 1'b0, 1'b0, '0);
      plan_beat(-16'sh0001, 1'b1, 1'b0, '0);
      // zero depth: wet and dry are the same sample, output equals input
      plan_write(CSR_DEPTH, 23'd0);
      plan_beat(16'sh7fff, 1'b0, 1'b1, 16'sh7fff);
      plan_beat(-16'sh8000, 1'b1, 1'b1, -16'sh8000);
      plan_beat(16'sh0001, 1'b0, 1'b1, 16'sh0001);
      // fastest lfo with the longest store, phase wraps every second beat
      plan_write(CSR_PHASE_STEP, 23'h7fffff);
      plan_write(CSR_DEPTH, 23'h3ffff);
      plan_beat(16'sh7fff, 1'b0, 1'b0, '0);
      plan_beat(-16'sh8000, 1'b1, 1'b0, '0);
      plan_beat(16'sh3039, 1'b0, 1'b0, '0);
      plan_beat(-16'sh0001, 1'b0, 1'b0, '0);
      plan_beat(16'sh0000, 1'b1, 1'b0, '0);
      // frozen lfo
      plan_write(CSR_PHASE_STEP, 23'd0);
      plan_beat(-16'sh8000, 1'b0, 1'b0, '0);
      plan_beat(16'sh7fff, 1'b1, 1'b0, '0);
      plan_beat(16'sh0064, 1'b0, 1'b0, '0);
      // bypass mid-stream leaves the store and lfo alone
      plan_write(CSR_ENABLE, 23'd0);
      plan_beat(16'sh7fff, 1'b1, 1'b1, 16'sh0000);
      plan_write(CSR_ENABLE, 23'd1);
      // the spare index is ignored
      plan_write(CSR_SPARE, 23'h7fffff);
      plan_beat(-16'sh8000, 1'b0, 1'b0, '0);
      plan_beat(16'sh7fff, 1'b1, 1'b0, '0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) write_csr(plan[i].index, plan[i].value);
         else drive_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end

      // random phases: new settings, then a stream of beats in bursts
      while (beats_sent < ITEM_TARGET) begin
         word = $urandom_range(0, 5) == 0 ? 23'd0 : 23'd1;
         if ($urandom_range(0, 3) == 0) word = word | (23'($urandom) << 1);
         write_csr(CSR_ENABLE, word);

         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0:       step_pick = '0;
               1:       step_pick = '1;
               2, 3:    step_pick = STEP_W'($urandom_range(1, 20000));
               default: step_pick = STEP_W'($urandom);
            endcase
            write_csr(CSR_PHASE_STEP, 23'(step_pick));
         end

         if ($urandom_range(0, 9) < 7) begin
            // mostly short stores so the line wraps many times per phase
            case ($urandom_range(0, 7))
               0:       depth_pick = '0;
               1:       depth_pick = '1;
               2:       depth_pick = DEPTH_W'($urandom_range(0, 511));
               3, 4:    depth_pick = DEPTH_W'($urandom_range(0, 16383));
               5:       depth_pick = DEPTH_W'($urandom_range(16384, 262143));
               default: depth_pick = DEPTH_W'($urandom_range(0, 4095));
            endcase
            word = 23'(depth_pick);
            if ($urandom_range(0, 3) == 0) word = word | (23'($urandom) << DEPTH_W);
            write_csr(CSR_DEPTH, word);
         end

         phase_len  = $urandom_range(60, 160);
         gappy      = $urandom_range(0, 3) != 0;
         burst_left = $urandom_range(1, 20);
         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               0:       beat.sample_in = 16'sh7fff;
               1:       beat.sample_in = -16'sh8000;
               2:       beat.sample_in = 16'(int'($urandom_range(0, 64)) - 32);
               default: beat.sample_in = 16'($urandom);
            endcase
            beat.block_end = $urandom_range(0, 7) == 0;
            drive_beat(beat, 1'b0, '0);
            if (gappy) begin
               burst_left--;
               if (burst_left == 0) begin
                  idle_gap($urandom_range(1, 12));
                  burst_left = $urandom_range(1, 20);
               end
            end
         end
      end

      // drain, then a quiet tail in case anything stray comes out
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   // stalls on its own pattern: stretches of fixed stall odds, including none,
   // plus a long hold-off now and then so the core fills and stalls its input
   initial begin : receiver
      int stretch_left, stall_pct, hold_left, next_hold;
      rsp_stall    = 1'b0;
      stretch_left = 0;
      stall_pct    = 0;
      hold_left    = 0;
      next_hold    = 500;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && beats_in >= next_hold) begin
            hold_left = HOLD_CYCLES;
            next_hold = next_hold + 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(30, 300);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 15;
                  2:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            stretch_left--;
            rsp_stall <= $urandom_range(0, 99) < stall_pct;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
